/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the gate generator modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

/* rtl/core/stpwm_pkg.sv */
// ----------------------------------------------------------------------------
// stpwm_pkg
// types, register codes and constant tables of the sine-triangle gate generator
// ----------------------------------------------------------------------------
package stpwm_pkg;

  localparam int PAT_BITS  = 60;
  localparam int CAR_BITS  = 18;
  localparam int LEG_TABLE = 30;
  localparam int LEG_BITS  = 5;
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;

  // register reset values
  localparam logic [15:0]         CARRIER_AMP_RST   = 16'd2500;
  localparam logic [15:0]         CARRIER_STEP_RST  = 16'd10;
  localparam logic [15:0]         REF_AMP_RST       = 16'd3536;
  localparam logic [31:0]         PHASE_STEP_RST    = 32'd42950;
  localparam logic [7:0]          LOOKAHEAD_RST     = 8'd1;
  localparam logic [PAT_BITS-1:0] INIT_PATTERN_RST  = '0;

  // state after reset: one lookahead tick from time zero, carrier still rising
  localparam logic [31:0] PHASE_RST =
    32'(longint'(PHASE_STEP_RST) * longint'(LOOKAHEAD_RST));
  localparam logic signed [CAR_BITS-1:0] CARRIER_RST =
    CAR_BITS'(-int'(CARRIER_AMP_RST) + int'(CARRIER_STEP_RST));

  // Q30 sine polynomial coefficients
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] COEF1   = 64'd1686629713;
  localparam logic [63:0] COEF3   = 64'd693598669;
  localparam logic [63:0] COEF5   = 64'd85569306;
  localparam logic [63:0] COEF7   = 64'd5026995;
  localparam logic [63:0] COEF9   = 64'd172272;

  typedef enum logic [2:0] {
    REG_CARRIER_AMP  = 3'd0,
    REG_CARRIER_STEP = 3'd1,
    REG_REF_AMP      = 3'd2,
    REG_PHASE_STEP   = 3'd3,
    REG_LOOKAHEAD    = 3'd4,
    REG_INIT_PATTERN = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_EVAL,
    S_DRAIN,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [15:0]         carrier_amp;
    logic [15:0]         carrier_step;
    logic [15:0]         ref_amp;
    logic [31:0]         phase_step;
    logic [7:0]          lookahead;
    logic [PAT_BITS-1:0] init_pattern;
  } cfg_t;

  typedef struct packed {
    logic                load_init;
    logic                advance;
    logic                issue;
    logic [LEG_BITS-1:0] leg;
    logic                finish;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

  // quarter-wave magnitude at index i, evaluated at elaboration only
  function automatic logic [63:0] sine_mag(int unsigned i, int unsigned qbits,
                                           int unsigned sbits);
    logic [63:0] x;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] full;
    x = 64'(i) << (30 - qbits);
    u = (x * x) >> 30;
    p = COEF9;
    p = COEF7 - ((p * u) >> 30);
    p = COEF5 - ((p * u) >> 30);
    p = COEF3 - ((p * u) >> 30);
    p = COEF1 - ((p * u) >> 30);
    y = (p * x) >> 30;
    if (y > Q30_ONE) y = Q30_ONE;
    full = (64'd1 << (sbits - 1)) - 64'd1;
    return (y * full + (Q30_ONE >> 1)) >> 30;
  endfunction

  // degrees to phase units, rounded
  function automatic logic [31:0] leg_ofs(int deg);
    int          dm;
    logic [63:0] num;
    dm = deg % 360;
    if (dm < 0) dm = dm + 360;
    num = (64'(dm) << 32) + 64'd180;
    return 32'(num / 64'd360);
  endfunction

  localparam logic [31:0] LEG_OFFSET [LEG_TABLE] = '{
    leg_ofs(0),    leg_ofs(180),  leg_ofs(-72),  leg_ofs(108),  leg_ofs(-144),
    leg_ofs(36),   leg_ofs(-216), leg_ofs(-36),  leg_ofs(-288), leg_ofs(-108),
    leg_ofs(-12),  leg_ofs(168),  leg_ofs(-84),  leg_ofs(96),   leg_ofs(-156),
    leg_ofs(24),   leg_ofs(-228), leg_ofs(-48),  leg_ofs(-300), leg_ofs(-120),
    leg_ofs(-24),  leg_ofs(156),  leg_ofs(-96),  leg_ofs(84),   leg_ofs(-168),
    leg_ofs(12),   leg_ofs(-240), leg_ofs(-60),  leg_ofs(-312), leg_ofs(-132)
  };

endpackage

/* rtl/core/sine_triangle_pwm_gate_generator.sv */
// ----------------------------------------------------------------------------
// sine_triangle_pwm_gate_generator
// sinusoidal pwm gate pattern from a shared sine reference and triangle carrier
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid_i / in_stall_o / restart_i): one request per
//   simulation tick; restart_i high restarts time at zero, low advances a tick
// - output channel (out_valid_o / out_stall_i): exactly one result per request
//   with the gate pattern, the mask of toggled switches and an any-changed flag
// - apb port: six registers at byte address 8*i, 64-bit data, always ready;
//   write them only while no request is in flight
// - timing: a tick request's legs go one per cycle through the single sine
//   rom read port and multiplier, followed by pipeline drain and handoff; a
//   restart first runs the lookahead carrier ticks; the block takes no new
//   request until it is back in idle after the handoff
// - the result sits in an output register, so a stalled receiver holds it
//   while the block returns to idle; it waits only if a second result is due
// - reset loads the register defaults and the state one lookahead tick ahead
// ----------------------------------------------------------------------------
module sine_triangle_pwm_gate_generator #(
  parameter int NUM_SWITCHES   = 60,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SINE_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tick requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stpwm_pkg::PAT_BITS-1:0]      gate_pattern_o,
  output logic [stpwm_pkg::PAT_BITS-1:0]      changed_mask_o,
  output logic                                any_changed_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stpwm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [stpwm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [stpwm_pkg::DATA_BITS-1:0]     prdata,
  output logic                                pready
);

  stpwm_pkg::cfg_t       cfg_q;
  stpwm_pkg::cmd_t       cmd;
  stpwm_pkg::status_t    status;
  stpwm_pkg::cfg_reg_e   reg_sel;
  logic                  reg_write;

  // register decode: 8-byte stride, low address bits ignored
  assign reg_sel   = stpwm_pkg::cfg_reg_e'(paddr[5:3]);
  assign reg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carrier_amp  <= stpwm_pkg::CARRIER_AMP_RST;
      cfg_q.carrier_step <= stpwm_pkg::CARRIER_STEP_RST;
      cfg_q.ref_amp      <= stpwm_pkg::REF_AMP_RST;
      cfg_q.phase_step   <= stpwm_pkg::PHASE_STEP_RST;
      cfg_q.lookahead    <= stpwm_pkg::LOOKAHEAD_RST;
      cfg_q.init_pattern <= stpwm_pkg::INIT_PATTERN_RST;
    end else if (reg_write) begin
      case (reg_sel)
        stpwm_pkg::REG_CARRIER_AMP:  cfg_q.carrier_amp  <= pwdata[15:0];
        stpwm_pkg::REG_CARRIER_STEP: cfg_q.carrier_step <= pwdata[15:0];
        stpwm_pkg::REG_REF_AMP:      cfg_q.ref_amp      <= pwdata[15:0];
        stpwm_pkg::REG_PHASE_STEP:   cfg_q.phase_step   <= pwdata[31:0];
        stpwm_pkg::REG_LOOKAHEAD:    cfg_q.lookahead    <= pwdata[7:0];
        stpwm_pkg::REG_INIT_PATTERN: cfg_q.init_pattern <= pwdata[stpwm_pkg::PAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    case (reg_sel)
      stpwm_pkg::REG_CARRIER_AMP:  prdata = 64'(cfg_q.carrier_amp);
      stpwm_pkg::REG_CARRIER_STEP: prdata = 64'(cfg_q.carrier_step);
      stpwm_pkg::REG_REF_AMP:      prdata = 64'(cfg_q.ref_amp);
      stpwm_pkg::REG_PHASE_STEP:   prdata = 64'(cfg_q.phase_step);
      stpwm_pkg::REG_LOOKAHEAD:    prdata = 64'(cfg_q.lookahead);
      stpwm_pkg::REG_INIT_PATTERN: prdata = 64'(cfg_q.init_pattern);
      default:                     prdata = '0;
    endcase
  end

  // sequencer: restart ticks, one leg per cycle, then result handoff
  stpwm_ctrl #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .lookahead_i (cfg_q.lookahead),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // phase/carrier state, sine compare pipeline and output register
  stpwm_datapath #(
    .NUM_SWITCHES   (NUM_SWITCHES),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SINE_BITS      (SINE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gate_pattern_o (gate_pattern_o),
    .changed_mask_o (changed_mask_o),
    .any_changed_o  (any_changed_o)
  );

endmodule

/* rtl/core/stpwm_sine_rom.sv */
// ----------------------------------------------------------------------------
// stpwm_sine_rom
// quarter-wave sine magnitude rom with registered read
// ----------------------------------------------------------------------------
module stpwm_sine_rom #(
  parameter int QBITS    = 8,
  parameter int MAG_BITS = 15
) (
  input  logic                clk_i,
  input  logic [QBITS:0]      addr_i,
  output logic [MAG_BITS-1:0] data_o
);

  localparam int Depth = (1 << QBITS) + 1;

  logic [MAG_BITS-1:0] rom [Depth];
  logic [MAG_BITS-1:0] data_q;

  for (genvar g = 0; g < Depth; g++) begin : g_rom
    assign rom[g] = MAG_BITS'(stpwm_pkg::sine_mag(g, QBITS, MAG_BITS + 1));
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

/* rtl/core/stpwm_datapath.sv */
// ----------------------------------------------------------------------------
// stpwm_datapath
// phase and carrier state, per-leg compare pipeline and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stpwm_datapath #(
  parameter int NUM_SWITCHES   = 60,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SINE_BITS      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stpwm_pkg::cfg_t                    cfg_i,
  input  stpwm_pkg::cmd_t                    cmd_i,
  output stpwm_pkg::status_t                 status_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [stpwm_pkg::PAT_BITS-1:0]     gate_pattern_o,
  output logic [stpwm_pkg::PAT_BITS-1:0]     changed_mask_o,
  output logic                               any_changed_o
);

  localparam int QB   = SINE_ADDR_BITS - 2;
  localparam int MagW = SINE_BITS - 1;
  localparam int PW   = 16 + MagW;
  localparam int CW   = stpwm_pkg::CAR_BITS + SINE_BITS + 1;
  localparam int CarW = stpwm_pkg::CAR_BITS;
  localparam int PatW = stpwm_pkg::PAT_BITS;
  localparam int LegW = stpwm_pkg::LEG_BITS;
  localparam logic [QB:0] Qlen = {1'b1, {QB{1'b0}}};

  // phase and carrier state
  logic [31:0]             phase_q, phase_d;
  logic signed [CarW-1:0]  carrier_q, carrier_d;
  logic                    rising_q, rising_d;
  logic signed [CarW:0]    amp_s, step_s, neg_amp, car_ext, tick_sum;

  always_comb begin
    amp_s   = $signed({3'b000, cfg_i.carrier_amp});
    step_s  = $signed({3'b000, cfg_i.carrier_step});
    neg_amp = -amp_s;
    car_ext = {carrier_q[CarW-1], carrier_q};
    phase_d   = phase_q;
    carrier_d = carrier_q;
    rising_d  = rising_q;
    tick_sum  = car_ext;
    if (cmd_i.load_init) begin
      phase_d   = '0;
      carrier_d = neg_amp[CarW-1:0];
      rising_d  = 1'b1;
    end else if (cmd_i.advance) begin
      phase_d = phase_q + cfg_i.phase_step;
      if (rising_q) begin
        tick_sum = car_ext + step_s;
        if (tick_sum >= amp_s) begin
          carrier_d = amp_s[CarW-1:0];
          rising_d  = 1'b0;
        end else begin
          carrier_d = tick_sum[CarW-1:0];
        end
      end else begin
        tick_sum = car_ext - step_s;
        if (tick_sum <= neg_amp) begin
          carrier_d = neg_amp[CarW-1:0];
          rising_d  = 1'b1;
        end else begin
          carrier_d = tick_sum[CarW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= stpwm_pkg::PHASE_RST;
      carrier_q <= stpwm_pkg::CARRIER_RST;
      rising_q  <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      carrier_q <= carrier_d;
      rising_q  <= rising_d;
    end
  end

  // stage 1: phase of the leg, rom address
  logic [31:0]             phase_sum;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [1:0]              quad;
  logic [QB:0]             rom_addr;
  logic [MagW-1:0]         rom_data;

  always_comb begin
    phase_sum = phase_q + stpwm_pkg::LEG_OFFSET[cmd_i.leg];
    sine_addr = phase_sum[31 -: SINE_ADDR_BITS];
    quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
    rom_addr  = quad[0] ? (Qlen - {1'b0, sine_addr[QB-1:0]})
                        : {1'b0, sine_addr[QB-1:0]};
  end

  stpwm_sine_rom #(
    .QBITS    (QB),
    .MAG_BITS (MagW)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  logic            s1_valid_q, s2_valid_q;
  logic [LegW-1:0] s1_leg_q, s2_leg_q;
  logic            s1_neg_q, s2_neg_q;
  logic [PW-1:0]   prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  // stage 2: scale by reference amplitude
  always_ff @(posedge clk_i) begin
    s1_leg_q <= cmd_i.leg;
    s1_neg_q <= quad[1];
    s2_leg_q <= s1_leg_q;
    s2_neg_q <= s1_neg_q;
    prod_q   <= PW'(cfg_i.ref_amp) * PW'(rom_data);
  end

  // stage 3: compare with carrier and set the leg's two gates
  logic signed [CW-1:0] ref_val, car_val;
  logic                 above;
  logic [5:0]           bit_lo, bit_hi;

  always_comb begin
    ref_val = s2_neg_q ? -$signed(CW'(prod_q)) : $signed(CW'(prod_q));
    car_val = $signed({{(CW - CarW){carrier_q[CarW-1]}}, carrier_q}) <<< (SINE_BITS - 1);
    above   = ref_val > car_val;
    bit_lo  = {s2_leg_q, 1'b0};
    bit_hi  = {s2_leg_q, 1'b1};
  end

  logic [PatW-1:0] work_q;
  logic [PatW-1:0] prev_q;
  logic [PatW-1:0] gate_pattern_q, changed_q;
  logic            any_q;
  logic            out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_init || cmd_i.advance) begin
      work_q <= '0;
    end else if (s2_valid_q) begin
      work_q[bit_lo] <= above;
      if (32'(bit_hi) < NUM_SWITCHES) begin
        work_q[bit_hi] <= !above;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= stpwm_pkg::INIT_PATTERN_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_init) begin
        prev_q <= cfg_i.init_pattern;
      end else if (cmd_i.finish) begin
        prev_q <= work_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      gate_pattern_q <= work_q;
      changed_q      <= work_q ^ prev_q;
      any_q          <= |(work_q ^ prev_q);
    end
  end

  assign status_o.pipe_busy = s1_valid_q | s2_valid_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign gate_pattern_o = gate_pattern_q;
  assign changed_mask_o = changed_q;
  assign any_changed_o  = any_q;

  `ASSERT_PROP(a_pipe_order, clk_i, rst_ni, s2_valid_q |-> $past(s1_valid_q))
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_i.finish && out_valid_q && out_stall_i)
  `ASSERT_PROP(a_prev_follows, clk_i, rst_ni, cmd_i.finish |=> (prev_q == gate_pattern_q) && (any_q == (changed_q != '0)))

endmodule

/* rtl/core/stpwm_ctrl.sv */
// ----------------------------------------------------------------------------
// stpwm_ctrl
// sequencer: lookahead ticks on restart, one leg per cycle, result handoff
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stpwm_ctrl #(
  parameter int NUM_SWITCHES = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  input  logic [7:0]         lookahead_i,
  input  stpwm_pkg::status_t status_i,
  output stpwm_pkg::cmd_t    cmd_o
);

  localparam int LegW = stpwm_pkg::LEG_BITS;
  localparam int Sw   = (NUM_SWITCHES < stpwm_pkg::PAT_BITS) ? NUM_SWITCHES
                                                           : stpwm_pkg::PAT_BITS;
  localparam int NumLegs = (Sw + 1) / 2;
  localparam logic [LegW-1:0] LastLeg = LegW'(NumLegs - 1);

  stpwm_pkg::ctrl_state_e state_q, state_d;
  logic [7:0]      tick_cnt_q, tick_cnt_d;
  logic [LegW-1:0] leg_q, leg_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stpwm_pkg::S_IDLE;
      tick_cnt_q <= '0;
      leg_q      <= '0;
    end else begin
      state_q    <= state_d;
      tick_cnt_q <= tick_cnt_d;
      leg_q      <= leg_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    tick_cnt_d = tick_cnt_q;
    leg_d      = leg_q;
    cmd_o      = '0;
    cmd_o.leg  = leg_q;
    in_stall_o = (state_q != stpwm_pkg::S_IDLE);
    accept     = in_valid_i && !in_stall_o;
    case (state_q)
      stpwm_pkg::S_IDLE: begin
        if (accept) begin
          leg_d = '0;
          if (restart_i) begin
            cmd_o.load_init = 1'b1;
            tick_cnt_d      = lookahead_i;
            state_d = (lookahead_i != '0) ? stpwm_pkg::S_TICK : stpwm_pkg::S_EVAL;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = stpwm_pkg::S_EVAL;
          end
        end
      end
      stpwm_pkg::S_TICK: begin
        cmd_o.advance = 1'b1;
        tick_cnt_d    = tick_cnt_q - 8'd1;
        if (tick_cnt_q == 8'd1) begin
          state_d = stpwm_pkg::S_EVAL;
        end
      end
      stpwm_pkg::S_EVAL: begin
        cmd_o.issue = 1'b1;
        if (leg_q == LastLeg) begin
          leg_d   = '0;
          state_d = stpwm_pkg::S_DRAIN;
        end else begin
          leg_d = leg_q + LegW'(1);
        end
      end
      stpwm_pkg::S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = stpwm_pkg::S_FINISH;
        end
      end
      stpwm_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = stpwm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stpwm_pkg::S_IDLE;
      end
    endcase
  end

  `ASSERT_NEVER(a_issue_alone, clk_i, rst_ni, cmd_o.issue && (cmd_o.load_init || cmd_o.advance))
  `ASSERT_NEVER(a_finish_drained, clk_i, rst_ni, cmd_o.finish && status_i.pipe_busy)
  `ASSERT_PROP(a_accept_starts, clk_i, rst_ni, accept |=> (state_q != stpwm_pkg::S_IDLE))

endmodule

/* dv/gate_pattern_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_pattern_checker
// watches the request, result and register channels of the gate generator,
// predicts each gate pattern and compares it with the block's result
// ----------------------------------------------------------------------------
module gate_pattern_checker #(
  parameter int NUM_SWITCHES   = 60,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SINE_BITS      = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            restart_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [stpwm_pkg::PAT_BITS-1:0]  gate_pattern_i,
  input  logic [stpwm_pkg::PAT_BITS-1:0]  changed_mask_i,
  input  logic                            any_changed_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [stpwm_pkg::ADDR_BITS-1:0] paddr_i,
  input  logic [stpwm_pkg::DATA_BITS-1:0] pwdata_i,
  input  logic                            pready_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int          PatW       = stpwm_pkg::PAT_BITS;
  localparam int          QBITS      = SINE_ADDR_BITS - 2;
  localparam logic [63:0] Q30        = 64'd1073741824;
  localparam logic [63:0] SINE_FULL  = (64'd1 << (SINE_BITS - 1)) - 64'd1;
  localparam logic [63:0] TAYLOR1    = 64'd1686629713;
  localparam logic [63:0] TAYLOR3    = 64'd693598669;
  localparam logic [63:0] TAYLOR5    = 64'd85569306;
  localparam logic [63:0] TAYLOR7    = 64'd5026995;
  localparam logic [63:0] TAYLOR9    = 64'd172272;
  localparam int          LEG_COUNT  = 30;
  localparam logic [PatW-1:0] PAT_MASK = '1;

  localparam int LEG_DEG [LEG_COUNT] = '{
    0, 180, -72, 108, -144, 36, -216, -36, -288, -108,
    -12, 168, -84, 96, -156, 24, -228, -48, -300, -120,
    -24, 156, -96, 84, -168, 12, -240, -60, -312, -132
  };

  typedef struct packed {
    logic [PatW-1:0] gate;
    logic [PatW-1:0] changed;
    logic            any;
  } gate_result_t;

  // register copies
  logic [15:0]     amp_reg;
  logic [15:0]     step_reg;
  logic [15:0]     ref_amp_reg;
  logic [31:0]     phase_step_reg;
  logic [7:0]      lookahead_reg;
  logic [PatW-1:0] init_pat_reg;

  // predicted block state
  logic [31:0]     ref_phase;
  int              carrier_now;
  logic            carrier_up;
  logic [PatW-1:0] prev_pattern;

  gate_result_t    expected_gates [$];
  int unsigned     mismatches;

  function automatic logic [31:0] degrees_to_phase(int deg);
    int          dm;
    logic [63:0] scaled;
    dm = deg % 360;
    if (dm < 0) dm = dm + 360;
    scaled = (64'(dm) << 32) + 64'd180;
    return 32'(scaled / 64'd360);
  endfunction

  function automatic longint sine_at(logic [31:0] ph);
    logic [31:0] addr;
    logic [1:0]  quad;
    logic [31:0] idx;
    logic [63:0] x;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] y;
    longint      mag;
    addr = ph >> (32 - SINE_ADDR_BITS);
    quad = 2'(addr >> QBITS);
    idx  = addr & ((32'd1 << QBITS) - 32'd1);
    if (quad[0]) idx = (32'd1 << QBITS) - idx;
    x = 64'(idx) << (30 - QBITS);
    u = (x * x) >> 30;
    p = TAYLOR9;
    p = TAYLOR7 - ((p * u) >> 30);
    p = TAYLOR5 - ((p * u) >> 30);
    p = TAYLOR3 - ((p * u) >> 30);
    p = TAYLOR1 - ((p * u) >> 30);
    y = (p * x) >> 30;
    if (y > Q30) y = Q30;
    mag = longint'((y * SINE_FULL + (Q30 >> 1)) >> 30);
    return quad[1] ? -mag : mag;
  endfunction

  // triangle carrier, clamped only when crossing the bound it heads for
  function automatic void step_carrier();
    int a;
    int s;
    a = int'(amp_reg);
    s = int'(step_reg);
    if (carrier_up) begin
      carrier_now = carrier_now + s;
      if (carrier_now >= a) begin
        carrier_now = a;
        carrier_up  = 1'b0;
      end
    end else begin
      carrier_now = carrier_now - s;
      if (carrier_now <= -a) begin
        carrier_now = -a;
        carrier_up  = 1'b1;
      end
    end
  endfunction

  function automatic void reload_state();
    ref_phase   = phase_step_reg * {24'd0, lookahead_reg};
    carrier_now = -int'(amp_reg);
    carrier_up  = 1'b1;
    for (int k = 0; k < int'(lookahead_reg); k++) step_carrier();
    prev_pattern = init_pat_reg;
  endfunction

  function automatic logic [PatW-1:0] predict_gates();
    logic [63:0] pat;
    longint      carrier_scaled;
    longint      sv;
    logic        above;
    int          leg;
    pat = '0;
    carrier_scaled = longint'(carrier_now) * (longint'(1) << (SINE_BITS - 1));
    for (int n = 0; n < NUM_SWITCHES && n < PatW; n++) begin
      leg   = n >> 1;
      sv    = sine_at(ref_phase + degrees_to_phase(LEG_DEG[leg % LEG_COUNT]));
      above = (longint'(ref_amp_reg) * sv) > carrier_scaled;
      if (n % 2 == 1 ? !above : above) pat[n] = 1'b1;
    end
    return pat[PatW-1:0] & PAT_MASK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gate_result_t    want;
    logic [PatW-1:0] pat;
    logic [PatW-1:0] chg;
    if (!rst_ni) begin
      amp_reg        = 16'd2500;
      step_reg       = 16'd10;
      ref_amp_reg    = 16'd3536;
      phase_step_reg = 32'd42950;
      lookahead_reg  = 8'd1;
      init_pat_reg   = '0;
      reload_state();
      expected_gates.delete();
      mismatches     = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (stpwm_pkg::cfg_reg_e'(paddr_i[5:3]))
          stpwm_pkg::REG_CARRIER_AMP:  amp_reg        = pwdata_i[15:0];
          stpwm_pkg::REG_CARRIER_STEP: step_reg       = pwdata_i[15:0];
          stpwm_pkg::REG_REF_AMP:      ref_amp_reg    = pwdata_i[15:0];
          stpwm_pkg::REG_PHASE_STEP:   phase_step_reg = pwdata_i[31:0];
          stpwm_pkg::REG_LOOKAHEAD:    lookahead_reg  = pwdata_i[7:0];
          stpwm_pkg::REG_INIT_PATTERN: init_pat_reg   = pwdata_i[PatW-1:0];
          default: ;
        endcase
      end

      // results first: a result accepted now belongs to an older request
      if (out_valid_i && !out_stall_i) begin
        if (expected_gates.size() == 0) begin
          $error("result with no request waiting: gate_pattern %h", gate_pattern_i);
          mismatches++;
        end else begin
          want = expected_gates.pop_front();
          if (gate_pattern_i !== want.gate) begin
            $error("gate_pattern expected %h actual %h", want.gate, gate_pattern_i);
            mismatches++;
          end
          if (changed_mask_i !== want.changed) begin
            $error("changed_mask expected %h actual %h", want.changed, changed_mask_i);
            mismatches++;
          end
          if (any_changed_i !== want.any) begin
            $error("any_changed expected %b actual %b", want.any, any_changed_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (restart_i) begin
          reload_state();
        end else begin
          ref_phase = ref_phase + phase_step_reg;
          step_carrier();
        end
        pat = predict_gates();
        chg = pat ^ prev_pattern;
        prev_pattern = pat;
        want.gate    = pat;
        want.changed = chg;
        want.any     = (chg != '0);
        expected_gates.push_back(want);
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_gates.size();
    end
  end

endmodule

/* dv/tb_sine_triangle_pwm_gate_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_triangle_pwm_gate_generator
// drives tick and restart requests and register settings into the gate
// generator, with random gaps and result stalls; the checker beside the
// block predicts every gate pattern and counts mismatches
// ----------------------------------------------------------------------------
module tb_sine_triangle_pwm_gate_generator;

  // generous: a few times the slowest legal run (all restarts at max lookahead)
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int          RAND_PHASES  = 9;
  localparam int          PHASE_ITEMS  = 95;

  logic                            clk_i       = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            restart     = 1'b0;
  logic                            out_stall   = 1'b0;
  logic                            psel        = 1'b0;
  logic                            penable     = 1'b0;
  logic                            pwrite      = 1'b0;
  logic [stpwm_pkg::ADDR_BITS-1:0] paddr       = '0;
  logic [stpwm_pkg::DATA_BITS-1:0] pwdata      = '0;

  logic                            in_stall_o;
  logic                            out_valid_o;
  logic [stpwm_pkg::PAT_BITS-1:0]  gate_pattern_o;
  logic [stpwm_pkg::PAT_BITS-1:0]  changed_mask_o;
  logic                            any_changed_o;
  logic [stpwm_pkg::DATA_BITS-1:0] prdata;
  logic                            pready;

  int unsigned          fail_count;
  int unsigned          pending;

  // when set, the receiver starts no new stall, though one already running ends first (stretches without back-pressure)
  bit                   no_stall = 1'b0;
  int unsigned          stall_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  sine_triangle_pwm_gate_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .gate_pattern_o (gate_pattern_o),
    .changed_mask_o (changed_mask_o),
    .any_changed_o  (any_changed_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  gate_pattern_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .restart_i      (restart),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .gate_pattern_i (gate_pattern_o),
    .changed_mask_i (changed_mask_o),
    .any_changed_i  (any_changed_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver back-pressure: mostly free, short stalls often, long ones rarely
  always @(posedge clk_i or negedge rst_n) begin
    int unsigned roll;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (no_stall || roll < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (roll < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 60);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // sender gap: mostly back-to-back, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // one request; payload holds while stalled, valid stays up when gap is 0
  task automatic send_request(input logic restart_bit, input int unsigned gap);
    in_valid <= 1'b1;
    restart  <= restart_bit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender stops until every predicted result has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // the checker count is registered, and let the block settle before any write
    repeat (4) @(posedge clk_i);
  endtask

  // apb write: setup phase, access phase, then an idle phase
  task automatic write_reg(input stpwm_pkg::cfg_reg_e idx,
                           input logic [stpwm_pkg::DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0]                     amp;
    logic [15:0]                     stp;
    logic [15:0]                     refa;
    logic [31:0]                     phs;
    logic [7:0]                      look;
    logic [stpwm_pkg::DATA_BITS-1:0] init;
    bit                              burst;

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----

    // plain ticks at the reset settings, back-to-back, then a restart and one more tick
    repeat (3) send_request(1'b0, 0);
    send_request(1'b1, 2);
    send_request(1'b0, 1);

    // no lookahead, every gate assumed on before the first tick
    wait_results_done();
    write_reg(stpwm_pkg::REG_LOOKAHEAD, 64'd0);
    write_reg(stpwm_pkg::REG_INIT_PATTERN, {4'h0, {stpwm_pkg::PAT_BITS{1'b1}}});
    send_request(1'b1, 0);
    repeat (2) send_request(1'b0, 0);

    // zero amplitude, zero step, zero reference: applied without restart first
    wait_results_done();
    write_reg(stpwm_pkg::REG_CARRIER_AMP, 64'd0);
    write_reg(stpwm_pkg::REG_CARRIER_STEP, 64'd0);
    write_reg(stpwm_pkg::REG_REF_AMP, 64'd0);
    repeat (2) send_request(1'b0, 1);
    send_request(1'b1, 0);

    // every register but the initial pattern at its top value, longest lookahead
    wait_results_done();
    write_reg(stpwm_pkg::REG_CARRIER_AMP, 64'hFFFF);
    write_reg(stpwm_pkg::REG_CARRIER_STEP, 64'hFFFF);
    write_reg(stpwm_pkg::REG_REF_AMP, 64'hFFFF);
    write_reg(stpwm_pkg::REG_PHASE_STEP, 64'hFFFF_FFFF);
    write_reg(stpwm_pkg::REG_LOOKAHEAD, 64'hFF);
    write_reg(stpwm_pkg::REG_INIT_PATTERN, 64'h0A5A_5A5A_5A5A_5A5A);
    send_request(1'b1, 0);
    repeat (2) send_request(1'b0, 0);

    // bound and step shrunk to one, with the carrier left at zero
    wait_results_done();
    write_reg(stpwm_pkg::REG_CARRIER_AMP, 64'd1);
    write_reg(stpwm_pkg::REG_CARRIER_STEP, 64'd1);
    repeat (3) send_request(1'b0, 0);

    // frozen phase, tiny reference
    wait_results_done();
    write_reg(stpwm_pkg::REG_PHASE_STEP, 64'd0);
    write_reg(stpwm_pkg::REG_REF_AMP, 64'd1);
    send_request(1'b1, 0);
    repeat (2) send_request(1'b0, 0);

    // small carrier that clamps at both bounds within a few ticks
    wait_results_done();
    write_reg(stpwm_pkg::REG_CARRIER_STEP, 64'd2);
    write_reg(stpwm_pkg::REG_CARRIER_AMP, 64'd3);
    write_reg(stpwm_pkg::REG_LOOKAHEAD, 64'd7);
    send_request(1'b1, 0);
    repeat (3) send_request(1'b0, 0);

    // ---- random phases, each under its own register setting ----
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       amp = 16'd1;
        1:       amp = 16'hFFFF;
        default: amp = 16'($urandom_range(40, 6000));
      endcase
      case ($urandom_range(0, 9))
        0:       stp = 16'd1;
        1:       stp = 16'hFFFF;
        2:       stp = 16'd0;
        default: stp = 16'($urandom_range(1, amp / 6 + 1));
      endcase
      case ($urandom_range(0, 7))
        0:       refa = 16'd0;
        1:       refa = 16'hFFFF;
        default: refa = (amp > 16'd32767) ? 16'($urandom)
                                          : 16'($urandom_range(0, 2 * amp));
      endcase
      case ($urandom_range(0, 7))
        0:       phs = 32'd0;
        1:       phs = 32'hFFFF_FFFF;
        2, 3:    phs = $urandom;
        default: phs = $urandom_range(10000, 50000000);
      endcase
      case ($urandom_range(0, 9))
        0:       look = 8'hFF;
        1:       look = 8'd0;
        2:       look = 8'($urandom);
        default: look = 8'($urandom_range(1, 4));
      endcase
      init  = {4'h0, 28'($urandom), 32'($urandom)};
      burst = ($urandom_range(0, 3) == 0);

      // between phases the sender also waits out every result
      wait_results_done();
      write_reg(stpwm_pkg::REG_CARRIER_AMP, 64'(amp));
      write_reg(stpwm_pkg::REG_CARRIER_STEP, 64'(stp));
      write_reg(stpwm_pkg::REG_REF_AMP, 64'(refa));
      write_reg(stpwm_pkg::REG_PHASE_STEP, 64'(phs));
      write_reg(stpwm_pkg::REG_LOOKAHEAD, 64'(look));
      write_reg(stpwm_pkg::REG_INIT_PATTERN, init);
      no_stall = burst;

      // mostly restart under the new setting, sometimes let the old state run on
      if ($urandom_range(0, 3) != 0) send_request(1'b1, burst ? 0 : pick_gap());

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request($urandom_range(0, 11) == 0, burst ? 0 : pick_gap());
        // occasional full drain mid-phase
        if ($urandom_range(0, 149) == 0) wait_results_done();
      end
      no_stall = 1'b0;
    end

    // ---- wind down ----
    wait_results_done();
    repeat (64) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
